[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the hash table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk outside reset.
`define AST_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by another.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/htdar_pkg.sv]
// Package with request codes, register indexes and constants of the hash table core.
package htdar_pkg;

  localparam int INDEX_BITS_DEFAULT = 16;
  localparam int MOVE_BITS_DEFAULT  = 16;

  localparam logic [1:0] REQ_PROBE = 2'd0;
  localparam logic [1:0] REQ_PUT   = 2'd1;
  localparam logic [1:0] REQ_AGE   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic CFG_ENTRIES_LOG2  = 1'b0;
  localparam logic CFG_TABLE_ENABLED = 1'b1;

  localparam logic [4:0]  ENTRIES_LOG2_RESET = 5'd16;
  localparam logic [2:0]  AGE_MAX    = 3'd7;
  localparam logic [2:0]  AGE_WRITE  = 3'd1;
  localparam logic [15:0] SCORE_NONE = 16'h8000;

  localparam int IN_DATA_BITS  = 128;
  localparam int OUT_DATA_BITS = 48;

endpackage

[rtl/core/hash_table_depth_age_replace_core.sv]
// Direct-mapped transposition table with depth and age based replacement.
// The block takes one request item on the s_ channel and returns exactly one result item
// on the m_ channel for each. The request kind travels in s_tuser: probe, put, age sweep
// or clear sweep. The slot index is the low key bits, masked by the size in use.
// A probe or a put reads the slot from synchronous memory in the cycle of acceptance and
// writes it back in the lookup state, where the result is loaded once the output is free.
// With 2^n slots in use an age sweep visits each slot with a read state and a write
// state; a clear sweep writes one slot per cycle. With the table disabled both go
// straight to the response state.
// One request is in work at a time; the next is taken as soon as the result sits in the
// output register, even while that result still waits for m_tready.
// When the receiver stalls, the block holds its finished result and its write-back until
// the output register is free.
// After reset the block clears all 2^INDEX_BITS slots, one per cycle, before it accepts
// its first item; configuration writes are taken at any time, with cfg_ready always high.
// Configuration writes are meant to happen only while the block is idle.
`include "assert_macros.svh"

module hash_table_depth_age_replace_core #(
  parameter int INDEX_BITS = htdar_pkg::INDEX_BITS_DEFAULT,
  parameter int MOVE_BITS  = htdar_pkg::MOVE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request items.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // key, depth, move, score, bound type, mate_threat, forced, zero fill
  input  logic [htdar_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // req_type
  input  logic [1:0]                            s_tuser,
  // Result items.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // entry_depth, entry_move, entry_score, entry_type, entry_mate_threat, entry_age, zero fill
  output logic [htdar_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // hit, stored
  output logic [1:0]                            m_tuser,
  // Configuration writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [4:0]                            cfg_data
);

  localparam int SLOTS = 1 << INDEX_BITS;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_AGE_RD = 3'd3;
  localparam logic [2:0] ST_AGE_WR = 3'd4;
  localparam logic [2:0] ST_CLR    = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  typedef struct packed {
    logic signed [7:0]      depth;
    logic [MOVE_BITS-1:0]   move;
    logic signed [15:0]     score;
    logic [1:0]             vtype;
    logic                   mate;
    logic [2:0]             age;
  } pay_t;

  localparam pay_t PAY_BLANK = '{
    depth: 8'sd0,
    move:  '0,
    score: htdar_pkg::SCORE_NONE,
    vtype: 2'd0,
    mate:  1'b0,
    age:   htdar_pkg::AGE_WRITE
  };

  logic [63:0] key_mem [SLOTS];
  pay_t        pay_mem [SLOTS];

  logic [2:0]             state;
  logic [INDEX_BITS-1:0]  idx;
  logic [4:0]             entries_log2;
  logic                   table_enabled;

  logic [1:0]             req_type;
  logic [63:0]            req_key;
  logic signed [7:0]      req_depth;
  logic [MOVE_BITS-1:0]   req_move;
  logic signed [15:0]     req_score;
  logic [1:0]             req_vtype;
  logic                   req_mate;
  logic                   req_forced;
  logic                   req_en;

  logic [63:0]            key_rd;
  pay_t                   pay_rd;

  logic                   in_accept;
  logic                   lookup_req;
  logic                   out_free;
  logic [4:0]             size_log2;
  logic [INDEX_BITS-1:0]  mask;
  logic [INDEX_BITS-1:0]  acc_idx;
  logic [INDEX_BITS-1:0]  rd_addr;
  logic                   rd_en;
  logic                   key_we;
  logic [63:0]            key_wdata;
  logic                   pay_we;
  pay_t                   pay_wdata;

  logic                   key_match;
  logic                   key_empty;
  logic [2:0]             age_dec;
  logic                   probe_hit;
  logic                   put_ok;
  pay_t                   put_pay;
  pay_t                   hit_pay;
  logic                   lookup_done;
  logic                   lookup_stall;
  logic                   resp_done;
  logic                   out_load;
  logic [htdar_pkg::OUT_DATA_BITS-1:0] lookup_data;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign lookup_req = (s_tuser == htdar_pkg::REQ_PROBE) || (s_tuser == htdar_pkg::REQ_PUT);
  assign out_free   = !m_tvalid || m_tready;

  assign size_log2 = (entries_log2 > 5'(INDEX_BITS)) ? 5'(INDEX_BITS) : entries_log2;
  assign mask      = ~({INDEX_BITS{1'b1}} << size_log2);
  assign acc_idx   = s_tdata[INDEX_BITS-1:0] & mask;

  assign rd_addr = (state == ST_IDLE) ? acc_idx : idx;
  assign rd_en   = (in_accept && lookup_req) || (state == ST_AGE_RD);

  assign lookup_stall = (state == ST_LOOKUP) && !out_free;
  assign resp_done    = (state == ST_RESP) && out_free;
  assign out_load     = lookup_done || resp_done;

  // Lookup decision on the registered slot read at acceptance.
  always_comb begin
    key_match = (key_rd == req_key);
    key_empty = (key_rd == 64'd0);
    age_dec   = (pay_rd.age != 3'd0) ? pay_rd.age - 3'd1 : pay_rd.age;
    probe_hit = req_en && (req_type == htdar_pkg::REQ_PROBE) && key_match;
    put_ok    = req_en && (req_type == htdar_pkg::REQ_PUT)
                && (key_empty || key_match || (req_depth > pay_rd.depth)
                    || ((req_depth == pay_rd.depth)
                        && (req_forced || pay_rd.age != 3'd0)));
    put_pay.depth = req_depth;
    put_pay.move  = (!key_empty && key_match && req_move == '0) ? pay_rd.move : req_move;
    put_pay.score = req_score;
    put_pay.vtype = req_vtype;
    put_pay.mate  = req_mate;
    put_pay.age   = htdar_pkg::AGE_WRITE;
    hit_pay       = pay_rd;
    hit_pay.age   = age_dec;
    lookup_done   = (state == ST_LOOKUP) && out_free;
    lookup_data   = '0;
    if (probe_hit) begin
      lookup_data[7:0]   = hit_pay.depth;
      lookup_data[23:8]  = 16'(hit_pay.move);
      lookup_data[39:24] = hit_pay.score;
      lookup_data[41:40] = hit_pay.vtype;
      lookup_data[42]    = hit_pay.mate;
      lookup_data[45:43] = hit_pay.age;
    end
  end

  // Write-back selection.
  always_comb begin
    key_we    = 1'b0;
    key_wdata = req_key;
    pay_we    = 1'b0;
    pay_wdata = put_pay;
    unique case (state) inside
      ST_LOOKUP: begin
        if (lookup_done) begin
          if (req_type == htdar_pkg::REQ_PUT) begin
            key_we = put_ok;
            pay_we = put_ok;
          end else begin
            pay_we    = probe_hit;
            pay_wdata = hit_pay;
          end
        end
      end
      ST_AGE_WR: begin
        pay_we        = !key_empty && (pay_rd.age != htdar_pkg::AGE_MAX);
        pay_wdata     = pay_rd;
        pay_wdata.age = pay_rd.age + 3'd1;
      end
      ST_INIT, ST_CLR: begin
        key_we    = 1'b1;
        key_wdata = 64'd0;
        pay_we    = 1'b1;
        pay_wdata = PAY_BLANK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[idx] <= key_wdata;
    end
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[idx] <= pay_wdata;
    end
    if (rd_en) begin
      pay_rd <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_log2  <= htdar_pkg::ENTRIES_LOG2_RESET;
      table_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        htdar_pkg::CFG_ENTRIES_LOG2:  entries_log2  <= cfg_data;
        htdar_pkg::CFG_TABLE_ENABLED: table_enabled <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type   <= s_tuser;
      req_key    <= s_tdata[63:0];
      req_depth  <= s_tdata[71:64];
      req_move   <= MOVE_BITS'(s_tdata[103:72]);
      req_score  <= s_tdata[119:104];
      req_vtype  <= s_tdata[121:120];
      req_mate   <= s_tdata[122];
      req_forced <= s_tdata[123];
      req_en     <= table_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= (state == ST_LOOKUP) ? lookup_data : '0;
      m_tuser <= (state == ST_LOOKUP) ? {put_ok, probe_hit} : 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_INIT: begin
          idx <= idx + INDEX_BITS'(1);
          if (idx == {INDEX_BITS{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            unique case (s_tuser) inside
              htdar_pkg::REQ_PROBE, htdar_pkg::REQ_PUT: begin
                idx   <= acc_idx;
                state <= ST_LOOKUP;
              end
              htdar_pkg::REQ_AGE: begin
                idx   <= '0;
                state <= table_enabled ? ST_AGE_RD : ST_RESP;
              end
              htdar_pkg::REQ_CLEAR: begin
                idx   <= '0;
                state <= table_enabled ? ST_CLR : ST_RESP;
              end
              default: begin
                idx   <= '0;
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_LOOKUP: begin
          if (lookup_done) begin
            state <= ST_IDLE;
          end
        end
        ST_AGE_RD: begin
          state <= ST_AGE_WR;
        end
        ST_AGE_WR: begin
          idx <= idx + INDEX_BITS'(1);
          state <= (idx == mask) ? ST_RESP : ST_AGE_RD;
        end
        ST_CLR: begin
          idx <= idx + INDEX_BITS'(1);
          if (idx == mask) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AST_CHECK(a_hit_xor_stored, !(m_tvalid && m_tuser[0] && m_tuser[1]), "hit and stored both set")
  `AST_CHECK(a_miss_zero, !(m_tvalid && !m_tuser[0]) || (m_tdata == '0), "miss with entry data")
  `AST_NEXT(a_lookup_follows, in_accept && lookup_req, state == ST_LOOKUP, "no lookup")
  `AST_NEXT(a_lookup_hold, lookup_stall, $stable(idx) && state == ST_LOOKUP, "lookup left")

endmodule
